>>> design/sbpm_pkg.sv
// -----------------------------------------------------------------------------
// Bar meter package
// Shared widths, codes, reset values and controller/datapath interface types.
// -----------------------------------------------------------------------------
package sbpm_pkg;

   // Field widths
   localparam int ACTION_W    = 2;
   localparam int BAND_W      = 6;
   localparam int NEW_LEVEL_W = 12;
   localparam int LEVEL_W     = 11;
   localparam int LEN_W       = 8;
   localparam int DECAY_W     = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DECAY = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_HOLD  = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY_STEP       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAR_MAX_LENGTH   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PEAK_FALL_STEP   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MARKER_THRESHOLD = 2'd3;

   // Register reset values
   localparam logic [DECAY_W-1:0] DECAY_STEP_RESET       = 10'd50;
   localparam logic [LEN_W-1:0]   BAR_MAX_LENGTH_RESET   = 8'd138;
   localparam logic [LEN_W-1:0]   PEAK_FALL_STEP_RESET   = 8'd2;
   localparam logic [LEN_W-1:0]   MARKER_THRESHOLD_RESET = 8'd3;

   // Level range, tenths of dB
   localparam logic signed [LEVEL_W-1:0]     LEVEL_RESET  = -11'sd900;
   localparam logic signed [NEW_LEVEL_W-1:0] LEVEL_MIN_12 = -12'sd900;
   localparam logic signed [NEW_LEVEL_W-1:0] LEVEL_MAX_12 = 12'sd0;
   localparam logic signed [NEW_LEVEL_W-1:0] LEVEL_SPAN_12 = 12'sd900;
   localparam int LEVEL_SPAN = 900;
   localparam int OFFSET_W   = 10;

   // Bar arithmetic: len^2 * offset / 900, then integer square root
   localparam int SQ_W        = 2 * LEN_W;
   localparam int PROD_W      = 26;
   localparam int RECIP_W     = 17;
   localparam int RECIP_SHIFT = 26;
   localparam logic [RECIP_W-1:0] RECIP = 17'd74565;  // floor(2^26 / 900)
   localparam int QUOT_W      = 16;
   localparam int REM_W       = 11;
   localparam int SQRT_STEPS  = 8;
   localparam int SQRT_CNT_W  = 3;
   localparam logic [QUOT_W-1:0] SQRT_BIT0 = 16'h4000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LEVEL,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_FIX,
      ST_SQRT,
      ST_PEAK,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic calc_level;
      logic mul1;
      logic mul2;
      logic mul3;
      logic fix;
      logic sqrt_step;
      logic write_back;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic in_range;
   } sts_type;

endpackage

>>> design/spectrum_bar_peak_hold_meter_core.sv
// -----------------------------------------------------------------------------
// Spectrum bar meter with peak hold and decay
// Per-band level meter. Each request beat names a band and an action: load a
// new level (clamped to -90..0 dB, tenths of dB), decay the stored level by
// decay_step (floored at -90 dB), or hold it. The bar length is then
// floor(bar_max_length * sqrt((level + 900) / 900)) and the peak marker either
// jumps up to the bar or falls by peak_fall_step toward zero.
// Channels: req_* in, rsp_* out, both valid/stall; csr_* writes the four
// registers by index and is always ready outside reset.
// Sequence: request capture, level update, three registered multiplies that
// form len^2 * offset and divide it by 900, a correction, the 8-step square
// root loop, peak update, then the response register once it is free; bands
// out of range go from the level update straight to the response register.
// A new request is taken only once the last one is in the response register.
// Reset clears the controller, registers and band valid bits, so every band
// reads as -90 dB with the peak at zero. A stalled response holds in its
// register; the next request finishes its work and waits for it to drain.
// -----------------------------------------------------------------------------
module spectrum_bar_peak_hold_meter_core
   import sbpm_pkg::*;
#(
   parameter int NUM_BANDS = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ACTION_W-1:0]           req_action,
   input  logic [BAND_W-1:0]             req_band,
   input  logic signed [NEW_LEVEL_W-1:0] req_new_level,
   // Response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [BAND_W-1:0]             rsp_band_out,
   output logic [LEN_W-1:0]              rsp_bar_length,
   output logic [LEN_W-1:0]              rsp_peak_length,
   output logic                          rsp_peak_shown,
   // Register write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   cmd_type cmd;
   sts_type sts;
   logic    csr_we;

   // Registers take a write any cycle outside reset
   assign csr_ready = !reset;
   assign csr_we    = csr_valid && csr_ready;

   sbpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   sbpm_dpath #(
      .NUM_BANDS (NUM_BANDS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_action      (req_action),
      .req_band        (req_band),
      .req_new_level   (req_new_level),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_band_out    (rsp_band_out),
      .rsp_bar_length  (rsp_bar_length),
      .rsp_peak_length (rsp_peak_length),
      .rsp_peak_shown  (rsp_peak_shown)
   );

endmodule

>>> design/sbpm_ctrl.sv
// -----------------------------------------------------------------------------
// Bar meter controller
// Sequences one beat through level update, divide, square root and write back.
// -----------------------------------------------------------------------------
module sbpm_ctrl
   import sbpm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  logic    rsp_stall,
   output logic    rsp_valid,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic [SQRT_CNT_W-1:0] sqrt_cnt_ff, sqrt_cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic sqrt_last;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign sqrt_last = (sqrt_cnt_ff == SQRT_CNT_W'(SQRT_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_LEVEL;
         ST_LEVEL: state_in = sts.in_range ? ST_MUL1 : ST_OUT;
         ST_MUL1:  state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_MUL3;
         ST_MUL3:  state_in = ST_FIX;
         ST_FIX:   state_in = ST_SQRT;
         ST_SQRT:  if (sqrt_last) state_in = ST_PEAK;
         ST_PEAK:  state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      req_stall      = reset || (state_ff != ST_IDLE);
      cmd.capture    = (state_ff == ST_IDLE) && req_valid && !reset;
      cmd.calc_level = (state_ff == ST_LEVEL);
      cmd.mul1       = (state_ff == ST_MUL1);
      cmd.mul2       = (state_ff == ST_MUL2);
      cmd.mul3       = (state_ff == ST_MUL3);
      cmd.fix        = (state_ff == ST_FIX);
      cmd.sqrt_step  = (state_ff == ST_SQRT);
      cmd.write_back = (state_ff == ST_PEAK);
      cmd.load_out   = (state_ff == ST_OUT) && out_free;
   end

   always_comb begin
      sqrt_cnt_in = sqrt_cnt_ff;
      if (cmd.fix) begin
         sqrt_cnt_in = '0;
      end else if (cmd.sqrt_step) begin
         sqrt_cnt_in = sqrt_cnt_ff + 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sqrt_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sqrt_cnt_ff  <= sqrt_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> design/sbpm_dpath.sv
// -----------------------------------------------------------------------------
// Bar meter datapath
// Band store, configuration registers, level update, divide by 900 and
// integer square root, peak update and result register.
// -----------------------------------------------------------------------------
module sbpm_dpath
   import sbpm_pkg::*;
#(
   parameter int NUM_BANDS = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ACTION_W-1:0]           req_action,
   input  logic [BAND_W-1:0]             req_band,
   input  logic signed [NEW_LEVEL_W-1:0] req_new_level,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata,
   input  cmd_type                       cmd,
   output sts_type                       sts,
   output logic [BAND_W-1:0]             rsp_band_out,
   output logic [LEN_W-1:0]              rsp_bar_length,
   output logic [LEN_W-1:0]              rsp_peak_length,
   output logic                          rsp_peak_shown
);

   localparam int IDX_W   = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
   localparam int EXT_W   = (IDX_W > BAND_W) ? IDX_W : BAND_W;
   localparam int CMP_W   = EXT_W + 1;
   localparam int ENTRY_W = LEVEL_W + LEN_W;
   localparam int RPROD_W = PROD_W + RECIP_W;

   // Configuration registers
   logic [DECAY_W-1:0] decay_step_ff;
   logic [LEN_W-1:0]   bar_max_length_ff;
   logic [LEN_W-1:0]   peak_fall_step_ff;
   logic [LEN_W-1:0]   marker_threshold_ff;

   // Band store: level and peak per band, valid bit marks written entries
   logic [ENTRY_W-1:0]   band_mem [NUM_BANDS];
   logic [NUM_BANDS-1:0] valid_ff;
   logic [ENTRY_W-1:0]   rd_entry_ff;
   logic                 rd_valid_ff;

   // Item registers
   logic [BAND_W-1:0]             band_ff;
   logic [ACTION_W-1:0]           action_ff;
   logic signed [NEW_LEVEL_W-1:0] new_level_ff;
   logic [IDX_W-1:0]              idx_ff;
   logic                          in_range_ff;

   // Arithmetic registers
   logic signed [LEVEL_W-1:0] level_ff;
   logic [OFFSET_W-1:0]       offset_ff;
   logic [LEN_W-1:0]          peak_old_ff;
   logic [SQ_W-1:0]           mm_ff;
   logic [PROD_W-1:0]         x_ff;
   logic [QUOT_W-1:0]         q0_ff;
   logic [REM_W-1:0]          rem_ff;
   logic [QUOT_W-1:0]         sq_v_ff;
   logic [QUOT_W-1:0]         root_ff;
   logic [QUOT_W-1:0]         sq_bit_ff;
   logic [LEN_W-1:0]          bar_ff;
   logic [LEN_W-1:0]          peak_ff;
   logic                      shown_ff;

   // Combinational
   logic [EXT_W-1:0]              req_band_ext;
   logic                          req_in_range;
   logic [IDX_W-1:0]              req_idx;
   logic signed [LEVEL_W-1:0]     cur_level;
   logic signed [NEW_LEVEL_W-1:0] cur12;
   logic signed [NEW_LEVEL_W-1:0] decayed;
   logic signed [NEW_LEVEL_W-1:0] lvl12;
   logic signed [NEW_LEVEL_W-1:0] off12;
   logic [RPROD_W-1:0]            recip_prod;
   logic [PROD_W-1:0]             q_times_span;
   logic [PROD_W-1:0]             rem_full;
   logic [QUOT_W-1:0]             q_fixed;
   logic [QUOT_W:0]               trial;
   logic [LEN_W-1:0]              bar_new;
   logic [LEN_W-1:0]              peak_new;

   assign req_band_ext = EXT_W'(req_band);
   assign req_in_range = (CMP_W'(req_band_ext) < CMP_W'(NUM_BANDS));
   assign req_idx      = req_in_range ? req_band_ext[IDX_W-1:0] : '0;
   assign sts.in_range = in_range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_step_ff       <= DECAY_STEP_RESET;
         bar_max_length_ff   <= BAR_MAX_LENGTH_RESET;
         peak_fall_step_ff   <= PEAK_FALL_STEP_RESET;
         marker_threshold_ff <= MARKER_THRESHOLD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DECAY_STEP:       decay_step_ff       <= csr_wdata[DECAY_W-1:0];
            CSR_BAR_MAX_LENGTH:   bar_max_length_ff   <= csr_wdata[LEN_W-1:0];
            CSR_PEAK_FALL_STEP:   peak_fall_step_ff   <= csr_wdata[LEN_W-1:0];
            CSR_MARKER_THRESHOLD: marker_threshold_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Band store access
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_entry_ff <= band_mem[req_idx];
      end
      if (cmd.write_back) begin
         band_mem[idx_ff] <= {level_ff, peak_new};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.capture) begin
            rd_valid_ff <= valid_ff[req_idx];
         end
         if (cmd.write_back) begin
            valid_ff[idx_ff] <= 1'b1;
         end
      end
   end

   // Level update
   assign cur_level = rd_valid_ff ? $signed(rd_entry_ff[ENTRY_W-1 -: LEVEL_W]) : LEVEL_RESET;
   assign cur12     = {cur_level[LEVEL_W-1], cur_level};
   assign decayed   = cur12 - $signed({2'b00, decay_step_ff});

   always_comb begin
      case (action_ff)
         ACT_LOAD: begin
            if (new_level_ff < LEVEL_MIN_12) begin
               lvl12 = LEVEL_MIN_12;
            end else if (new_level_ff > LEVEL_MAX_12) begin
               lvl12 = LEVEL_MAX_12;
            end else begin
               lvl12 = new_level_ff;
            end
         end
         ACT_DECAY: lvl12 = (decayed < LEVEL_MIN_12) ? LEVEL_MIN_12 : decayed;
         ACT_HOLD:  lvl12 = cur12;
         default:   lvl12 = cur12;
      endcase
   end

   assign off12 = lvl12 + LEVEL_SPAN_12;

   // Divide by the span through a reciprocal, then correct by one
   assign recip_prod   = RPROD_W'(x_ff) * RPROD_W'(RECIP);
   assign q_times_span = PROD_W'(q0_ff) * PROD_W'(LEVEL_SPAN);
   assign rem_full     = x_ff - q_times_span;
   assign q_fixed      = (rem_ff >= REM_W'(LEVEL_SPAN)) ? q0_ff + 1'b1 : q0_ff;

   // One square root step per cycle
   assign trial = {1'b0, root_ff} + {1'b0, sq_bit_ff};

   // Peak marker: jump up to the bar or fall toward zero
   assign bar_new = root_ff[LEN_W-1:0];

   always_comb begin
      if (peak_old_ff < bar_new) begin
         peak_new = bar_new;
      end else if (peak_old_ff > peak_fall_step_ff) begin
         peak_new = peak_old_ff - peak_fall_step_ff;
      end else begin
         peak_new = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         band_ff      <= req_band;
         action_ff    <= req_action;
         new_level_ff <= req_new_level;
         idx_ff       <= req_idx;
         in_range_ff  <= req_in_range;
      end
      if (cmd.calc_level) begin
         level_ff    <= lvl12[LEVEL_W-1:0];
         offset_ff   <= off12[OFFSET_W-1:0];
         peak_old_ff <= rd_valid_ff ? rd_entry_ff[LEN_W-1:0] : '0;
         mm_ff       <= SQ_W'(bar_max_length_ff) * SQ_W'(bar_max_length_ff);
      end
      if (cmd.mul1) begin
         x_ff <= PROD_W'(mm_ff) * PROD_W'(offset_ff);
      end
      if (cmd.mul2) begin
         q0_ff <= recip_prod[RECIP_SHIFT +: QUOT_W];
      end
      if (cmd.mul3) begin
         rem_ff <= rem_full[REM_W-1:0];
      end
      if (cmd.fix) begin
         sq_v_ff   <= q_fixed;
         root_ff   <= '0;
         sq_bit_ff <= SQRT_BIT0;
      end
      if (cmd.sqrt_step) begin
         if ({1'b0, sq_v_ff} >= trial) begin
            sq_v_ff <= sq_v_ff - trial[QUOT_W-1:0];
            root_ff <= (root_ff >> 1) + sq_bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         sq_bit_ff <= sq_bit_ff >> 2;
      end
      if (cmd.write_back) begin
         bar_ff   <= bar_new;
         peak_ff  <= peak_new;
         shown_ff <= (peak_new >= marker_threshold_ff);
      end
      if (cmd.load_out) begin
         rsp_band_out    <= band_ff;
         rsp_bar_length  <= in_range_ff ? bar_ff : '0;
         rsp_peak_length <= in_range_ff ? peak_ff : '0;
         rsp_peak_shown  <= in_range_ff && shown_ff;
      end
   end

endmodule

>>> design/sbpm_checker.sv
// -----------------------------------------------------------------------------
// Bar meter port checker
// Watches the top level ports for handshake and sequencing slips.
// -----------------------------------------------------------------------------
module sbpm_checker
   import sbpm_pkg::*;
#(
   parameter int NUM_BANDS = 48
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [BAND_W-1:0]             rsp_band_out,
   input logic [LEN_W-1:0]              rsp_bar_length,
   input logic [LEN_W-1:0]              rsp_peak_length,
   input logic                          rsp_peak_shown
);

   // A stalled response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // One request at a time: an accept closes the request channel
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous beat in flight");

   // Bands beyond the store answer with zero bar and peak
   a_out_of_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (int'(rsp_band_out) >= NUM_BANDS) |->
         (rsp_bar_length == '0) && (rsp_peak_length == '0) && !rsp_peak_shown)
      else $error("out of range band gave nonzero result");

   // Reset empties the response register
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind spectrum_bar_peak_hold_meter_core sbpm_checker #(
   .NUM_BANDS (NUM_BANDS)
) u_checker (.*);
